FILE: design/abkf_pkg.sv
// ----------------------------------------------------------------------------
// abkf_pkg: shared types and constants of the angle/bias kalman filter
// formats, command codes and the controller/datapath interface structs
// ----------------------------------------------------------------------------
package abkf_pkg;

    localparam int COV_FRAC_BITS = 24;
    localparam int DT_FRAC_BITS  = 24;
    localparam int REG_W         = 31;
    localparam int CFG_IDX_W     = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_NOISE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BIAS_NOISE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MEASURE_NOISE = 2'd2;

    // datapath operations, one per controller step
    typedef enum logic [4:0] {
        OP_NONE    = 5'd0,
        OP_LOAD    = 5'd1,   // latch input word
        OP_ANGLE   = 5'd2,   // angle += rmul(dt, bias)
        OP_DBB     = 5'd3,   // dbb = rmul(dt, cov_bb), inner
        OP_COVAA   = 5'd4,   // cov_aa += rmul(dt, inner)
        OP_COVX    = 5'd5,   // cov_ab, cov_ba -= dbb; cov_bb += rmul(bn, dt)
        OP_INNOV   = 5'd6,   // y, s, start k0 divide
        OP_DIVSTEP = 5'd7,   // one divider iteration
        OP_K0DONE  = 5'd8,   // save k0, start k1 divide
        OP_K1DONE  = 5'd9,   // save k1
        OP_UPD_A   = 5'd10,  // angle
        OP_UPD_B   = 5'd11,  // bias
        OP_UPD_AA  = 5'd12,
        OP_UPD_AB  = 5'd13,
        OP_UPD_BA  = 5'd14,
        OP_UPD_BB  = 5'd15
    } op_t;

    typedef struct packed {
        op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic div_done;
    } dp_status_t;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647) return 32'sh7fffffff;
        if (v < -66'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

endpackage

FILE: design/abkf_ctrl.sv
// ----------------------------------------------------------------------------
// abkf_ctrl: sequencing state machine
// steps the datapath through predict, divide and correct for one word
// ----------------------------------------------------------------------------
module abkf_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_fire,
    input  logic                   out_busy,
    input  logic                   out_fire,
    input  abkf_pkg::dp_status_t   status,
    output logic                   in_ready,
    output logic                   out_load,
    output abkf_pkg::dp_cmd_t      cmd
);

    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_ANGLE = 13'b0000000000010,
        S_DBB   = 13'b0000000000100,
        S_COVAA = 13'b0000000001000,
        S_COVX  = 13'b0000000010000,
        S_INNOV = 13'b0000000100000,
        S_DIV0  = 13'b0000001000000,
        S_DIV1  = 13'b0000010000000,
        S_UPDA  = 13'b0000100000000,
        S_UPDB  = 13'b0001000000000,
        S_UPDC  = 13'b0010000000000,
        S_UPDD  = 13'b0100000000000,
        S_OUT   = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;
    logic [1:0] sub_reg, sub_next;

    assign in_ready = (state_reg == S_IDLE);
    assign out_load = (state_reg == S_OUT) && (!out_busy || out_fire);

    always_comb begin
        state_next = state_reg;
        sub_next   = sub_reg;
        cmd.op     = abkf_pkg::OP_NONE;
        case (state_reg)
            S_IDLE: begin
                if (in_fire) begin
                    cmd.op = abkf_pkg::OP_LOAD;
                    state_next = S_ANGLE;
                end
            end
            S_ANGLE: begin cmd.op = abkf_pkg::OP_ANGLE; state_next = S_DBB; end
            S_DBB:   begin cmd.op = abkf_pkg::OP_DBB;   state_next = S_COVAA; end
            S_COVAA: begin cmd.op = abkf_pkg::OP_COVAA; state_next = S_COVX; end
            S_COVX:  begin cmd.op = abkf_pkg::OP_COVX;  state_next = S_INNOV; end
            S_INNOV: begin cmd.op = abkf_pkg::OP_INNOV; state_next = S_DIV0; end
            S_DIV0: begin
                if (status.div_done) begin
                    cmd.op = abkf_pkg::OP_K0DONE;
                    state_next = S_DIV1;
                end else begin
                    cmd.op = abkf_pkg::OP_DIVSTEP;
                end
            end
            S_DIV1: begin
                if (status.div_done) begin
                    cmd.op = abkf_pkg::OP_K1DONE;
                    state_next = S_UPDA;
                end else begin
                    cmd.op = abkf_pkg::OP_DIVSTEP;
                end
            end
            S_UPDA: begin cmd.op = abkf_pkg::OP_UPD_A; state_next = S_UPDB; end
            S_UPDB: begin cmd.op = abkf_pkg::OP_UPD_B; state_next = S_UPDC; sub_next = 2'd0; end
            S_UPDC: begin
                cmd.op = sub_reg[0] ? abkf_pkg::OP_UPD_AB : abkf_pkg::OP_UPD_AA;
                sub_next = sub_reg + 2'd1;
                if (sub_reg[0]) state_next = S_UPDD;
            end
            S_UPDD: begin
                cmd.op = sub_reg[0] ? abkf_pkg::OP_UPD_BB : abkf_pkg::OP_UPD_BA;
                sub_next = sub_reg + 2'd1;
                if (sub_reg[0]) state_next = S_OUT;
            end
            S_OUT: begin
                if (out_load) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            sub_reg   <= 2'd0;
        end else begin
            state_reg <= state_next;
            sub_reg   <= sub_next;
        end
    end

`ifndef ASSERT_OFF
    a_div_only_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == abkf_pkg::OP_DIVSTEP) |-> (state_reg == S_DIV0 || state_reg == S_DIV1))
        else $error("divide step outside divide states");
    a_load_from_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == abkf_pkg::OP_LOAD) |=> (state_reg == S_ANGLE))
        else $error("load did not start predict");
    a_out_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> (state_reg == S_IDLE))
        else $error("result handoff did not return to idle");
`endif

endmodule

FILE: design/abkf_datapath.sv
// ----------------------------------------------------------------------------
// abkf_datapath: filter state, one shared multiplier and a radix-2 divider
// one rounded product per step, restoring divide one quotient bit per cycle
// ----------------------------------------------------------------------------
module abkf_datapath (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  abkf_pkg::dp_cmd_t                 cmd,
    input  logic signed [31:0]                measured_angle,
    input  logic [23:0]                       time_step,
    input  logic [abkf_pkg::REG_W-1:0]        angle_noise,
    input  logic [abkf_pkg::REG_W-1:0]        bias_noise,
    input  logic [abkf_pkg::REG_W-1:0]        measure_noise,
    output abkf_pkg::dp_status_t              status,
    output logic signed [31:0]                angle_est,
    output logic signed [31:0]                bias_est,
    output logic                              fault
);

    localparam int QW = 32 + abkf_pkg::COV_FRAC_BITS; // dividend width
    localparam int DW = 34;                           // remainder width

    logic signed [31:0] angle_reg, bias_reg, aa_reg, ab_reg, ba_reg, bb_reg;
    logic signed [31:0] meas_reg, dbb_reg, inner_reg, y_reg, k0_reg, k1_reg;
    logic signed [31:0] p00_reg, p01_reg;
    logic [23:0]        dt_reg;
    logic [32:0]        s_reg;
    logic               fault_reg;

    // divider
    logic [QW-1:0]      q_reg;
    logic [DW-1:0]      rem_reg;
    logic               neg_reg;
    logic [6:0]         cnt_reg;

    // shared multiplier operands
    logic signed [32:0] ma, mb;
    logic signed [65:0] prod;
    logic signed [31:0] rprod;
    logic [4:0]         sh;

    always_comb begin
        ma = '0;
        mb = '0;
        sh = 5'(abkf_pkg::COV_FRAC_BITS);
        case (cmd.op)
            abkf_pkg::OP_ANGLE: begin
                ma = {9'd0, dt_reg}; mb = 33'(bias_reg);
                sh = 5'(abkf_pkg::DT_FRAC_BITS);
            end
            abkf_pkg::OP_DBB: begin
                ma = {9'd0, dt_reg}; mb = 33'(bb_reg);
                sh = 5'(abkf_pkg::DT_FRAC_BITS);
            end
            abkf_pkg::OP_COVAA: begin
                ma = {9'd0, dt_reg}; mb = 33'(inner_reg);
                sh = 5'(abkf_pkg::DT_FRAC_BITS);
            end
            abkf_pkg::OP_COVX: begin
                ma = {2'd0, bias_noise}; mb = {9'd0, dt_reg};
                sh = 5'(abkf_pkg::DT_FRAC_BITS);
            end
            abkf_pkg::OP_UPD_A: begin ma = 33'(k0_reg); mb = 33'(y_reg); end
            abkf_pkg::OP_UPD_B: begin ma = 33'(k1_reg); mb = 33'(y_reg); end
            abkf_pkg::OP_UPD_AA: begin ma = 33'(k0_reg); mb = 33'(p00_reg); end
            abkf_pkg::OP_UPD_AB: begin ma = 33'(k0_reg); mb = 33'(p01_reg); end
            abkf_pkg::OP_UPD_BA: begin ma = 33'(k1_reg); mb = 33'(p00_reg); end
            abkf_pkg::OP_UPD_BB: begin ma = 33'(k1_reg); mb = 33'(p01_reg); end
            default: begin ma = '0; mb = '0; end
        endcase
        prod = ma * mb + (66'sd1 <<< (sh - 5'd1));
        rprod = abkf_pkg::sat32(prod >>> sh);
    end

    // restoring divide of |num| * 2^frac by s
    logic [DW-1:0] trial;
    logic [DW-1:0] rem_sh;
    always_comb begin
        rem_sh = {rem_reg[DW-2:0], q_reg[QW-1]};
        trial  = rem_sh - {1'b0, s_reg};
    end

    logic [QW:0]          qmag;
    logic signed [QW+1:0] qsgn;
    logic signed [31:0]   qsat;
    always_comb begin
        qmag = {1'b0, q_reg};
        qsgn = neg_reg ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
        qsat = abkf_pkg::sat32(66'(qsgn));
    end

    assign status.div_done = (cnt_reg == 7'(QW));

    logic signed [32:0] num_src;
    logic [31:0]        num_abs;

    logic signed [65:0] t_angle, t_inner, t_y, t_s;
    always_comb begin
        t_angle = 66'(angle_reg) + 66'(rprod);
        t_inner = 66'(rprod) - 66'(ab_reg) - 66'(ba_reg) + $signed({35'd0, angle_noise});
        t_y     = 66'(meas_reg) - 66'(angle_reg);
        t_s     = 66'(aa_reg) + $signed({35'd0, measure_noise});
        num_src = (cmd.op == abkf_pkg::OP_K0DONE) ? 33'(ba_reg) : 33'(aa_reg);
        num_abs = num_src[32] ? 32'(-num_src) : num_src[31:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            angle_reg <= '0; bias_reg <= '0;
            aa_reg <= '0; ab_reg <= '0; ba_reg <= '0; bb_reg <= '0;
            fault_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            case (cmd.op)
                abkf_pkg::OP_LOAD: begin
                    meas_reg <= measured_angle;
                    dt_reg   <= time_step;
                end
                abkf_pkg::OP_ANGLE: angle_reg <= abkf_pkg::sat32(t_angle);
                abkf_pkg::OP_DBB: begin
                    dbb_reg   <= rprod;
                    inner_reg <= abkf_pkg::sat32(t_inner);
                end
                abkf_pkg::OP_COVAA: aa_reg <= abkf_pkg::sat32(66'(aa_reg) + 66'(rprod));
                abkf_pkg::OP_COVX: begin
                    ab_reg <= abkf_pkg::sat32(66'(ab_reg) - 66'(dbb_reg));
                    ba_reg <= abkf_pkg::sat32(66'(ba_reg) - 66'(dbb_reg));
                    bb_reg <= abkf_pkg::sat32(66'(bb_reg) + 66'(rprod));
                end
                abkf_pkg::OP_INNOV: begin
                    y_reg     <= abkf_pkg::sat32(t_y);
                    s_reg     <= t_s[32:0];
                    fault_reg <= (t_s <= 66'sd0);
                    q_reg     <= {num_abs, {abkf_pkg::COV_FRAC_BITS{1'b0}}};
                    neg_reg   <= num_src[32];
                    rem_reg   <= '0;
                    cnt_reg   <= (t_s <= 66'sd0) ? 7'(QW) : 7'd0;
                end
                abkf_pkg::OP_DIVSTEP: begin
                    if (!trial[DW-1]) begin
                        rem_reg <= trial;
                        q_reg   <= {q_reg[QW-2:0], 1'b1};
                    end else begin
                        rem_reg <= rem_sh;
                        q_reg   <= {q_reg[QW-2:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg + 7'd1;
                end
                abkf_pkg::OP_K0DONE: begin
                    k0_reg  <= fault_reg ? 32'sd0 : qsat;
                    q_reg   <= {num_abs, {abkf_pkg::COV_FRAC_BITS{1'b0}}};
                    neg_reg <= num_src[32];
                    rem_reg <= '0;
                    cnt_reg <= fault_reg ? 7'(QW) : 7'd0;
                end
                abkf_pkg::OP_K1DONE: begin
                    k1_reg  <= fault_reg ? 32'sd0 : qsat;
                    p00_reg <= aa_reg;
                    p01_reg <= ab_reg;
                end
                abkf_pkg::OP_UPD_A:  angle_reg <= abkf_pkg::sat32(66'(angle_reg) + 66'(rprod));
                abkf_pkg::OP_UPD_B:  bias_reg  <= abkf_pkg::sat32(66'(bias_reg) + 66'(rprod));
                abkf_pkg::OP_UPD_AA: aa_reg <= abkf_pkg::sat32(66'(aa_reg) - 66'(rprod));
                abkf_pkg::OP_UPD_AB: ab_reg <= abkf_pkg::sat32(66'(ab_reg) - 66'(rprod));
                abkf_pkg::OP_UPD_BA: ba_reg <= abkf_pkg::sat32(66'(ba_reg) - 66'(rprod));
                abkf_pkg::OP_UPD_BB: bb_reg <= abkf_pkg::sat32(66'(bb_reg) - 66'(rprod));
                default: ;
            endcase
        end
    end

    assign angle_est = angle_reg;
    assign bias_est  = bias_reg;
    assign fault     = fault_reg;

`ifndef ASSERT_OFF
    a_div_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= 7'(QW))
        else $error("divider count overrun");
    a_fault_skips_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == abkf_pkg::OP_K1DONE && fault_reg) |=> (k1_reg == 32'sd0))
        else $error("gain not forced to zero on fault");
    a_rem_below_s: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == abkf_pkg::OP_DIVSTEP) |=> (rem_reg < {1'b0, s_reg}))
        else $error("divider remainder out of range");
`endif

endmodule

FILE: design/angle_bias_kalman_filter.sv
// ----------------------------------------------------------------------------
// angle_bias_kalman_filter: two-state angle/bias kalman filter, one axis
// sequenced datapath with one shared multiplier and a bit-serial divider
// ----------------------------------------------------------------------------
// usage
//   s_axis: one word per sample, measured angle (q16.16) and time step (q0.24)
//   m_axis: one word per sample, filtered angle, bias estimate, divide fault
//   cfg: angle_noise, bias_noise, measure_noise written while idle
// computation
//   one word in computation; each word is carried through the two 56-step
//   restoring divides for the gains (one quotient bit a cycle, plus one
//   handoff step each), ten multiply steps on the shared multiplier, one
//   innovation step and one output step
//   a new word is accepted only after the last result enters the output register
//   on a divide fault both divides are skipped, only their handoff steps run
// reset
//   aresetn low zeroes the estimates and covariance and loads the default
//   noise registers; no clearing pass is needed
// stall
//   the result sits in an output register; while it waits the next word is
//   accepted and processed, the block holds only at handoff of that result
// ----------------------------------------------------------------------------
module angle_bias_kalman_filter (
    input  logic                       aclk,
    input  logic                       aresetn,
    // input channel
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [55:0]                s_tdata,   // measured_angle[31:0], time_step[55:32]
    // result channel
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [71:0]                m_tdata,   // filtered_angle, bias_estimate, divide_fault
    // configuration writes
    input  logic                       cfg_we,
    input  logic [abkf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [abkf_pkg::REG_W-1:0] cfg_data
);

    logic [abkf_pkg::REG_W-1:0] angle_noise_reg, bias_noise_reg, measure_noise_reg;

    // noise registers, out-of-range index ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            angle_noise_reg   <= 31'd16777;
            bias_noise_reg    <= 31'd50332;
            measure_noise_reg <= 31'd503316;
        end else if (cfg_we) begin
            case (cfg_index)
                abkf_pkg::CFG_ANGLE_NOISE:   angle_noise_reg   <= cfg_data;
                abkf_pkg::CFG_BIAS_NOISE:    bias_noise_reg    <= cfg_data;
                abkf_pkg::CFG_MEASURE_NOISE: measure_noise_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    abkf_pkg::dp_cmd_t    cmd;
    abkf_pkg::dp_status_t status;
    logic                 in_fire, out_fire, out_load;
    logic signed [31:0]   angle_est, bias_est;
    logic                 fault;
    logic                 m_valid_reg;
    logic [71:0]          m_data_reg;

    assign in_fire  = s_tvalid && s_tready;
    assign out_fire = m_valid_reg && m_tready;

    abkf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_fire  (in_fire),
        .out_busy (m_valid_reg),
        .out_fire (out_fire),
        .status   (status),
        .in_ready (s_tready),
        .out_load (out_load),
        .cmd      (cmd)
    );

    abkf_datapath u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .measured_angle (s_tdata[31:0]),
        .time_step      (s_tdata[55:32]),
        .angle_noise    (angle_noise_reg),
        .bias_noise     (bias_noise_reg),
        .measure_noise  (measure_noise_reg),
        .status         (status),
        .angle_est      (angle_est),
        .bias_est       (bias_est),
        .fault          (fault)
    );

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (out_fire) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg <= {7'd0, fault, bias_est, angle_est};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

`ifndef ASSERT_OFF
    a_no_accept_while_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |=> !s_tready)
        else $error("second word accepted mid-computation");
    a_load_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (!m_valid_reg || out_fire))
        else $error("result overwritten before taken");
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_tdata[71:65] == 7'd0))
        else $error("pad bits not zero");
`endif

endmodule
